/* hdl/ste_pkg.sv */
// shared types and codes for the sorted table engine
`timescale 1ns / 1ps

package ste_pkg;

  // operation codes carried on the op port
  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_GET    = 3'd2,
    OP_FIND   = 3'd3,
    OP_SET    = 3'd4
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_POS   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // where a moving cell takes its new entry from
  typedef enum logic {
    DIR_FROM_LEFT  = 1'b0,
    DIR_FROM_RIGHT = 1'b1
  } move_dir_t;

  // broadcast command to every cell of the row
  typedef struct packed {
    logic      load_en;
    logic      move_en;
    move_dir_t dir;
  } cell_cmd_t;

endpackage

/* hdl/ste_cell.sv */
// one table slot: holds an entry, compares it with the broadcast key, shifts along the row
`timescale 1ns / 1ps

module ste_cell #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32,
  parameter int IW         = 6,
  parameter int INDEX      = 0
) (
  input  logic                         clk,
  input  ste_pkg::cell_cmd_t           cmd,
  input  logic [IW-1:0]                load_pos,
  input  logic [IW-1:0]                move_lo,
  input  logic [IW-1:0]                move_hi,
  input  logic                         occupied,
  input  logic signed [KEY_BITS-1:0]   bcast_key,
  input  logic [VALUE_BITS-1:0]        bcast_value,
  input  logic signed [KEY_BITS-1:0]   left_key,
  input  logic [VALUE_BITS-1:0]        left_value,
  input  logic signed [KEY_BITS-1:0]   right_key,
  input  logic [VALUE_BITS-1:0]        right_value,
  output logic signed [KEY_BITS-1:0]   key,
  output logic [VALUE_BITS-1:0]        value,
  output logic                         lt,
  output logic                         le
);
  import ste_pkg::*;

  localparam logic [IW-1:0] IDX = IW'(INDEX);

  logic at_load;
  logic in_range;

  always_comb begin
    at_load  = cmd.load_en && (load_pos == IDX);
    in_range = cmd.move_en && (IDX >= move_lo) && (IDX <= move_hi);
  end

  always_ff @(posedge clk) begin
    if (at_load) begin
      key   <= bcast_key;
      value <= bcast_value;
    end else if (in_range) begin
      if (cmd.dir == DIR_FROM_LEFT) begin
        key   <= left_key;
        value <= left_value;
      end else begin
        key   <= right_key;
        value <= right_value;
      end
    end
  end

  // empty slots never count as below the key
  assign lt = occupied && (key < bcast_key);
  assign le = occupied && (key <= bcast_key);

endmodule

/* hdl/sorted_table_engine_top.sv */
// sorted key/value table built as a row of shifting cells with a small sequencer
`timescale 1ns / 1ps

// sorted_table_engine_top keeps up to DEPTH key/value entries in ascending
// signed key order, one entry per cell in a row of cells. every operation
// (insert, remove, get, find, set) goes from the input transfer to the result
// register through a compare step, where every cell compares its key with the
// operation key in parallel and the addressed entry is read, a count step that
// turns the compare flags into entry counts, and a shift step in which the
// whole row shifts left or right by one slot around the target position while
// the new entry is loaded. the row updates in the shift step whatever the
// position, so the cost does not depend on how full the table is.
// one operation is in flight at a time; the sequencer goes back to idle after
// the shift cycle and takes the next transfer there, not before. a new one is
// taken as soon as the sequencer is idle, even while the previous result
// still waits in the output register; it then holds in its shift cycle until
// that register is free. insert places a new entry after all equal keys, find
// returns the lowest position holding the key, set rewrites an entry and moves
// it just far enough to keep the order. insert into a full table answers
// status full, positions at or past the entry count answer bad position.
// table contents have no reset; reset clears the entry count, the sequencer
// state and out_valid.

module sorted_table_engine_top #(
  parameter int DEPTH      = 64,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [2:0]                           op,
  input  logic signed [KEY_BITS-1:0]           item_key,
  input  logic [VALUE_BITS-1:0]                item_value,
  input  logic [$clog2(DEPTH)-1:0]             position,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           status,
  output logic [$clog2(DEPTH)-1:0]             found_position,
  output logic signed [KEY_BITS-1:0]           out_key,
  output logic [VALUE_BITS-1:0]                out_value,
  output logic [$clog2(DEPTH+1)-1:0]           entry_count
);
  import ste_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_CNT,
    S_APPLY
  } state_t;

  state_t state;

  // captured operation
  op_t                         op_q;
  logic signed [KEY_BITS-1:0]  key_q;
  logic [VALUE_BITS-1:0]       value_q;
  logic [IW-1:0]               pos_q;

  // table occupancy
  logic [CW-1:0]               count;

  // per-cell signals
  logic signed [KEY_BITS-1:0]  cell_key [DEPTH];
  logic [VALUE_BITS-1:0]       cell_value [DEPTH];
  logic [DEPTH-1:0]            cell_lt;
  logic [DEPTH-1:0]            cell_le;
  logic [DEPTH-1:0]            occupied;

  // pipeline registers between the sequencer steps
  logic [DEPTH-1:0]            lt_flags;
  logic [DEPTH-1:0]            le_flags;
  logic signed [KEY_BITS-1:0]  rd_key_q;
  logic [VALUE_BITS-1:0]       rd_value_q;
  logic [CW-1:0]               lt_cnt;
  // insert slot: after every entry with equal or smaller key
  logic [CW-1:0]               le_cnt;
  logic [CW-1:0]               set_lo;
  logic [CW-1:0]               set_hi;

  // read port of the row
  logic [IW-1:0]               rd_addr;
  logic signed [KEY_BITS-1:0]  rd_key;
  logic [VALUE_BITS-1:0]       rd_value;

  // count step
  logic [CW-1:0]               lt_enc;
  logic [CW-1:0]               le_enc;
  logic                        ko_lt;
  logic                        ko_le;

  // apply step
  cell_cmd_t                   cmd;
  logic [IW-1:0]               load_pos;
  logic [IW-1:0]               move_lo;
  logic [IW-1:0]               move_hi;
  logic                        apply_fire;
  logic [CW-1:0]               pos_x;
  logic [CW-1:0]               set_p;
  logic [CW-1:0]               count_next;
  status_t                     res_status;
  logic [IW-1:0]               res_pos;
  logic signed [KEY_BITS-1:0]  res_key;
  logic [VALUE_BITS-1:0]       res_value;

  // number of leading ones in a sorted flag row (ones form a prefix)
  function automatic logic [CW-1:0] therm_count(input logic [DEPTH-1:0] f);
    logic [DEPTH:0] fx;
    logic [CW-1:0]  c;
    fx = {1'b0, f};
    c  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      c = c | ((fx[i] && !fx[i+1]) ? CW'(i + 1) : CW'(0));
    end
    return c;
  endfunction

  // row of cells, each taking from its neighbors when told to shift
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occupied[i] = (CW'(i) < count);

    ste_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .IW         (IW),
      .INDEX      (i)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .load_pos    (load_pos),
      .move_lo     (move_lo),
      .move_hi     (move_hi),
      .occupied    (occupied[i]),
      .bcast_key   (key_q),
      .bcast_value (value_q),
      .left_key    (cell_key[(i == 0) ? 0 : i - 1]),
      .left_value  (cell_value[(i == 0) ? 0 : i - 1]),
      .right_key   (cell_key[(i == DEPTH - 1) ? i : i + 1]),
      .right_value (cell_value[(i == DEPTH - 1) ? i : i + 1]),
      .key         (cell_key[i]),
      .value       (cell_value[i]),
      .lt          (cell_lt[i]),
      .le          (cell_le[i])
    );
  end

  // compare step reads the addressed entry, apply step reads the find candidate
  assign rd_addr  = (state == S_APPLY) ? lt_cnt[IW-1:0] : pos_q;
  assign rd_key   = cell_key[rd_addr];
  assign rd_value = cell_value[rd_addr];

  // counts of entries below the key, and the set window on the table without
  // the entry being rewritten
  always_comb begin
    lt_enc = therm_count(lt_flags);
    le_enc = therm_count(le_flags);
    ko_lt  = rd_key_q < key_q;
    ko_le  = rd_key_q <= key_q;
  end

  assign in_ready   = (state == S_IDLE);
  assign apply_fire = (state == S_APPLY) && (!out_valid || out_ready);

  // apply step: row command and result
  always_comb begin
    cmd        = '{load_en: 1'b0, move_en: 1'b0, dir: DIR_FROM_LEFT};
    load_pos   = '0;
    move_lo    = '0;
    move_hi    = '0;
    count_next = count;
    res_status = ST_OK;
    res_pos    = '0;
    res_key    = '0;
    res_value  = '0;
    pos_x      = CW'(pos_q);
    set_p      = pos_x;
    if (pos_x < set_lo) begin
      set_p = set_lo;
    end else if (pos_x > set_hi) begin
      set_p = set_hi;
    end

    unique case (op_q)
      OP_INSERT: begin
        if (count == CW'(DEPTH)) begin
          res_status = ST_FULL;
        end else begin
          // cells at and past the slot shift right, the slot loads the entry
          cmd        = '{load_en: 1'b1, move_en: 1'b1, dir: DIR_FROM_LEFT};
          load_pos   = le_cnt[IW-1:0];
          move_lo    = le_cnt[IW-1:0];
          move_hi    = IW'(DEPTH - 1);
          res_pos    = le_cnt[IW-1:0];
          count_next = count + CW'(1);
        end
      end
      OP_REMOVE: begin
        if (pos_x >= count) begin
          res_status = ST_BAD_POS;
        end else begin
          cmd        = '{load_en: 1'b0, move_en: 1'b1, dir: DIR_FROM_RIGHT};
          move_lo    = pos_q;
          move_hi    = IW'(DEPTH - 1);
          count_next = count - CW'(1);
        end
      end
      OP_GET: begin
        if (pos_x >= count) begin
          res_status = ST_BAD_POS;
        end else begin
          res_pos   = pos_q;
          res_key   = rd_key_q;
          res_value = rd_value_q;
        end
      end
      OP_FIND: begin
        if ((lt_cnt < count) && (rd_key == key_q)) begin
          res_pos   = lt_cnt[IW-1:0];
          res_key   = rd_key;
          res_value = rd_value;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      OP_SET: begin
        if (pos_x >= count) begin
          res_status = ST_BAD_POS;
        end else begin
          load_pos = set_p[IW-1:0];
          res_pos  = set_p[IW-1:0];
          if (set_p <= pos_x) begin
            // entry moves left: the gap between closes from the left
            cmd     = '{load_en: 1'b1, move_en: 1'b1, dir: DIR_FROM_LEFT};
            move_lo = set_p[IW-1:0];
            move_hi = pos_q;
          end else begin
            cmd     = '{load_en: 1'b1, move_en: 1'b1, dir: DIR_FROM_RIGHT};
            move_lo = pos_q;
            move_hi = set_p[IW-1:0];
          end
        end
      end
      default: begin
      end
    endcase

    if (!apply_fire) begin
      cmd = '{load_en: 1'b0, move_en: 1'b0, dir: DIR_FROM_LEFT};
    end
  end

  // sequencer, step registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // a new result replaces one leaving in the same cycle
      if (apply_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_CNT;
        end
        S_CNT: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (apply_fire) begin
            state <= S_IDLE;
            count <= count_next;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q    <= op_t'(op);
      key_q   <= item_key;
      value_q <= item_value;
      pos_q   <= position;
    end
    if (state == S_CMP) begin
      lt_flags   <= cell_lt;
      le_flags   <= cell_le;
      rd_key_q   <= rd_key;
      rd_value_q <= rd_value;
    end
    if (state == S_CNT) begin
      lt_cnt <= lt_enc;
      le_cnt <= le_enc;
      set_lo <= lt_enc - CW'(ko_lt);
      set_hi <= le_enc - CW'(ko_le);
    end
    if (apply_fire) begin
      status         <= res_status;
      found_position <= res_pos;
      out_key        <= res_key;
      out_value      <= res_value;
      entry_count    <= count_next;
    end
  end

endmodule
